// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`endif

// File: sv/ols_pkg.sv
// Types and constants shared by the ordered list store modules.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ols_pkg;

   localparam int OP_W    = 4;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 6;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 6;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 4'd5;
   localparam logic [OP_W-1:0] OP_READ_FWD  = 4'd6;
   localparam logic [OP_W-1:0] OP_READ_REV  = 4'd7;
   localparam logic [OP_W-1:0] OP_COUNT     = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   typedef enum logic [1:0] {
      K_INS,
      K_DEL,
      K_TRAV,
      K_NOP
   } kind_type;

   typedef enum logic [1:0] {
      L_FRONT,
      L_BACK,
      L_POS
   } loc_type;

   typedef struct packed {
      kind_type                 kind;
      loc_type                  loc;
      logic signed [VAL_W-1:0]  value;
      logic [POS_W-1:0]         position;
   } cmd_type;

endpackage

// File: sv/ols_front.sv
// Front end: takes request transfers and decodes them into list commands.
// Depends on ols_pkg; feeds ols_queue.
`timescale 1ns / 1ps

module ols_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ols_pkg::OP_W-1:0]     req_opcode,
   input  logic signed [ols_pkg::VAL_W-1:0] req_value,
   input  logic [ols_pkg::POS_W-1:0]    req_position,
   input  logic                         q_ready,
   output logic                         q_push,
   output ols_pkg::cmd_type             q_cmd
);
   import ols_pkg::*;

   assign req_stall = !q_ready;
   assign q_push    = req_valid && q_ready;

   always_comb begin
      q_cmd.value    = req_value;
      q_cmd.position = req_position;
      case (req_opcode)
         OP_INS_FRONT: begin
            q_cmd.kind = K_INS;
            q_cmd.loc  = L_FRONT;
         end
         OP_INS_BACK: begin
            q_cmd.kind = K_INS;
            q_cmd.loc  = L_BACK;
         end
         OP_INS_POS: begin
            q_cmd.kind = K_INS;
            q_cmd.loc  = L_POS;
         end
         OP_DEL_FRONT: begin
            q_cmd.kind = K_DEL;
            q_cmd.loc  = L_FRONT;
         end
         OP_DEL_BACK: begin
            q_cmd.kind = K_DEL;
            q_cmd.loc  = L_BACK;
         end
         OP_DEL_POS: begin
            q_cmd.kind = K_DEL;
            q_cmd.loc  = L_POS;
         end
         OP_READ_FWD: begin
            q_cmd.kind = K_TRAV;
            q_cmd.loc  = L_FRONT;
         end
         OP_READ_REV: begin
            q_cmd.kind = K_TRAV;
            q_cmd.loc  = L_BACK;
         end
         default: begin
            q_cmd.kind = K_NOP;
            q_cmd.loc  = L_FRONT;
         end
      endcase
   end

endmodule

// File: sv/ols_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on ols_pkg for the command type.
`timescale 1ns / 1ps

module ols_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ols_pkg::cmd_type push_cmd,
   output logic             ready,
   input  logic             pop,
   output logic             valid,
   output ols_pkg::cmd_type head
);
   import ols_pkg::*;

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   cmd_type             entry_ff [QDEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign ready = fill_ff != QCNT_W'(QDEPTH);
   assign valid = fill_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/ols_back.sv
// Back end: shifting cell chain, element count, traversal sequencer and
// the response output register. Depends on ols_pkg; fed by ols_queue.
`timescale 1ns / 1ps

module ols_back #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  ols_pkg::cmd_type                   q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ols_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ols_pkg::VAL_W-1:0]   rsp_value_out,
   output logic [ols_pkg::COUNT_W-1:0]        rsp_count_out,
   output logic                               rsp_last
);
   import ols_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic {
      S_IDLE,
      S_TRAV
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        trav_ff, trav_in;
   logic                    rev_ff, rev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic signed [VAL_W-1:0] cells_ff [DEPTH];
   logic signed [VAL_W-1:0] cells_in [DEPTH];

   logic                    slot_free;
   logic                    is_full;
   logic                    is_empty;
   logic                    mid;
   logic                    do_ins;
   logic                    do_del;
   logic [IDX_W-1:0]        edit_idx;
   logic [IDX_W-1:0]        pos_idx;
   logic [IDX_W-1:0]        rd_idx;
   logic                    trav_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_full   = count_ff == CNT_W'(DEPTH);
   assign is_empty  = count_ff == '0;
   assign mid       = (CMP_W'(q_head.position) > CMP_W'(1))
                      && (CMP_W'(q_head.position) < CMP_W'(count_ff));
   assign pos_idx   = IDX_W'(q_head.position - POS_W'(1));
   assign rd_idx    = rev_ff ? IDX_W'(count_ff - CNT_W'(1) - trav_ff) : IDX_W'(trav_ff);
   assign trav_last = (trav_ff + CNT_W'(1)) == count_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      trav_in       = trav_ff;
      rev_in        = rev_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      do_ins        = 1'b0;
      do_del        = 1'b0;
      edit_idx      = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               case (q_head.kind)
                  K_INS: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        case (q_head.loc)
                           L_FRONT: begin
                              do_ins = 1'b1;
                           end
                           L_BACK: begin
                              do_ins   = 1'b1;
                              edit_idx = IDX_W'(count_ff);
                           end
                           default: begin
                              if (mid) begin
                                 do_ins   = 1'b1;
                                 edit_idx = pos_idx;
                              end else begin
                                 rsp_status_in = ST_BADPOS;
                              end
                           end
                        endcase
                     end
                     if (do_ins) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  K_DEL: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        case (q_head.loc)
                           L_FRONT: begin
                              do_del = 1'b1;
                           end
                           L_BACK: begin
                              do_del   = 1'b1;
                              edit_idx = IDX_W'(count_ff - CNT_W'(1));
                           end
                           default: begin
                              if (mid) begin
                                 do_del   = 1'b1;
                                 edit_idx = pos_idx;
                              end else begin
                                 rsp_status_in = ST_BADPOS;
                              end
                           end
                        endcase
                     end
                     if (do_del) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  K_TRAV: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_TRAV;
                        trav_in      = '0;
                        rev_in       = q_head.loc == L_BACK;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         S_TRAV: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = cells_ff[rd_idx];
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = trav_last;
               trav_in       = trav_ff + CNT_W'(1);
               if (trav_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] prev_val;
      logic signed [VAL_W-1:0] next_val;

      if (g == 0) begin : g_head
         assign prev_val = cells_ff[g];
      end else begin : g_body
         assign prev_val = cells_ff[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_val = cells_ff[g];
      end else begin : g_inner
         assign next_val = cells_ff[g+1];
      end

      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_ins) begin
            if (IDX_W'(g) == edit_idx) begin
               cells_in[g] = q_head.value;
            end else if (IDX_W'(g) > edit_idx) begin
               cells_in[g] = prev_val;
            end
         end else if (do_del && (IDX_W'(g) >= edit_idx)) begin
            cells_in[g] = next_val;
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[g] <= cells_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         trav_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: sv/ordered_list_store_top.sv
// Top level of the ordered list store: front end, command queue, back end.
// Depends on ols_pkg, ols_front, ols_queue and ols_back.
`timescale 1ns / 1ps

// An ordered list of up to DEPTH signed 32-bit values, packed front first in
// a shifting register chain. Requests are decoded and queued two deep, so a
// new request transfer is taken while the back end works or its response
// waits. An insert, delete or count command passes through the queue entry
// and the response register; its edit is made at the edge that registers
// that response. A forward or reverse read gives one response per element,
// one per cycle while the receiver does not stall, after a setup step that
// takes the command; on an empty list it gives one empty-status response.
module ordered_list_store_top #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ols_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [ols_pkg::VAL_W-1:0]   req_value,
   input  logic [ols_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ols_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ols_pkg::VAL_W-1:0]   rsp_value_out,
   output logic [ols_pkg::COUNT_W-1:0]        rsp_count_out,
   output logic                               rsp_last
);
   import ols_pkg::*;

   logic    q_ready;
   logic    q_push;
   cmd_type q_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head;

   ols_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .q_ready      (q_ready),
      .q_push       (q_push),
      .q_cmd        (q_cmd)
   );

   ols_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   ols_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_count_out (rsp_count_out),
      .rsp_last      (rsp_last)
   );

endmodule

// File: sv/ols_checker.sv
// Port-level checks on the ordered list store responses, bound to the top.
// Depends on ols_pkg, assert_macros.svh and ordered_list_store_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ols_checker #(
   parameter int DEPTH = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ols_pkg::STAT_W-1:0]         rsp_status,
   input logic signed [ols_pkg::VAL_W-1:0]   rsp_value_out,
   input logic [ols_pkg::COUNT_W-1:0]        rsp_count_out,
   input logic                               rsp_last
);
   import ols_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")
   `ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_count_out == COUNT_W'(DEPTH), "full status with a count below capacity")
   `ASSERT_IMPL(a_empty_shape, clock, reset, rsp_valid && (rsp_status == ST_EMPTY), (rsp_count_out == '0) && (rsp_value_out == '0) && rsp_last, "empty status with data, count or more transfers")
   `ASSERT_IMPL(a_mid_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == ST_OK, "error status inside a traversal")

endmodule

bind ordered_list_store_top ols_checker #(
   .DEPTH (DEPTH)
) u_ols_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_value_out (rsp_value_out),
   .rsp_count_out (rsp_count_out),
   .rsp_last      (rsp_last)
);

// File: sim/tb_top.sv
// Self-checking testbench for ordered_list_store_top: directed table, then random commands.
// Depends on ols_pkg and the RTL of the block; predicts every response from its own list copy.
`timescale 1ns / 1ps

module tb_top;
   import ols_pkg::*;

   localparam int DEPTH     = 32;
   localparam int LIMIT     = 400000;
   localparam int HOLD_LEN  = 300;
   localparam int DRAIN_LEN = 40;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [VAL_W-1:0]  value;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } list_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [VAL_W-1:0]  value;
      logic [POS_W-1:0]         position;
      logic                     typed;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_opcode = '0;
   logic signed [VAL_W-1:0]   req_value = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [VAL_W-1:0]   rsp_value_out;
   logic [COUNT_W-1:0]        rsp_count_out;
   logic                      rsp_last;

   logic signed [VAL_W-1:0]   list_cells [DEPTH];
   int                        list_len = 0;
   list_rsp_type              pending_rsp[$];
   dir_row_type               directed_rows[$];
   int                        mismatches = 0;
   int                        cycles = 0;
   bit                        no_idle = 1'b0;
   int                        hold_token = 0;
   int                        hold_seen = 0;
   int                        hold_left = 0;

   ordered_list_store_top #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_count_out (rsp_count_out),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic void push_rsp(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] v,
                                    logic last);
      list_rsp_type r;
      r.status = st;
      r.value  = v;
      r.count  = COUNT_W'(list_len);
      r.last   = last;
      pending_rsp.push_back(r);
   endfunction

   function automatic void predict_list_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                           logic [POS_W-1:0] pos);
      bit               mid;
      logic [STAT_W-1:0] st;
      int               idx;
      int               i;
      mid = (pos > 1) && (pos < list_len);
      st  = ST_OK;
      idx = -1;
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (list_len >= DEPTH) st = ST_FULL;
            else if (op == OP_INS_FRONT) idx = 0;
            else if (op == OP_INS_BACK) idx = list_len;
            else if (mid) idx = pos - 1;
            else st = ST_BADPOS;
            if (idx >= 0) begin
               for (i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
               list_cells[idx] = v;
               list_len++;
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            if (list_len == 0) st = ST_EMPTY;
            else if (op == OP_DEL_FRONT) idx = 0;
            else if (op == OP_DEL_BACK) idx = list_len - 1;
            else if (mid) idx = pos - 1;
            else st = ST_BADPOS;
            if (idx >= 0) begin
               for (i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
               list_len--;
            end
         end
         OP_READ_FWD, OP_READ_REV: begin
            if (list_len == 0) begin
               push_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  idx = (op == OP_READ_FWD) ? i : list_len - 1 - i;
                  push_rsp(ST_OK, list_cells[idx], i + 1 == list_len);
               end
            end
            return;
         end
         default: begin
         end
      endcase
      push_rsp(st, '0, 1'b1);
   endfunction

   function automatic dir_row_type row(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                       logic [POS_W-1:0] pos, logic typed,
                                       logic [STAT_W-1:0] st, logic [COUNT_W-1:0] cnt);
      dir_row_type r;
      r.opcode   = op;
      r.value    = v;
      r.position = pos;
      r.typed    = typed;
      r.status   = st;
      r.count    = cnt;
      return r;
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if (list_len > 2 && $urandom_range(99) < 70) return POS_W'($urandom_range(list_len - 1, 2));
      return POS_W'($urandom_range(32));
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            default: return 32'h00000000;
         endcase
      end
      return $urandom;
   endfunction

   // One request transfer; the expected responses are queued at the accepting edge.
   task automatic send_command(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
                               input logic [POS_W-1:0] pos, input logic typed,
                               input list_rsp_type typed_rsp);
      while (!no_idle && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_value    <= v;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_list_op(op, v, pos);
      if (typed) begin
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(typed_rsp);
      end
   endtask

   task automatic send_random(input logic [OP_W-1:0] op);
      send_command(op, pick_value(), pick_position(), 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      list_rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: status %0d value %0d count %0d last %0d",
                           rsp_status, rsp_value_out, rsp_count_out, rsp_last);
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_status !== e.status || rsp_value_out !== e.value ||
                   rsp_count_out !== e.count || rsp_last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status %0d value %0d count %0d last %0d, %s %0d %0d %0d %0d",
                              e.status, e.value, e.count, e.last, "got",
                              rsp_status, rsp_value_out, rsp_count_out, rsp_last);
               end
            end
         end
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 35);
         end
      end
   end

   initial begin
      list_rsp_type tr;
      dir_row_type  d;
      int        k;
      int        r;
      int        ins_w;
      int        guard;
      logic [OP_W-1:0] op;

      directed_rows.push_back(row(OP_READ_FWD,  0, 0, 1, ST_EMPTY, 0));
      directed_rows.push_back(row(OP_READ_REV,  0, 0, 1, ST_EMPTY, 0));
      directed_rows.push_back(row(OP_DEL_FRONT, 0, 0, 1, ST_EMPTY, 0));
      directed_rows.push_back(row(OP_DEL_BACK,  0, 0, 1, ST_EMPTY, 0));
      directed_rows.push_back(row(OP_DEL_POS,   0, 2, 1, ST_EMPTY, 0));
      directed_rows.push_back(row(OP_INS_POS,   7, 1, 1, ST_BADPOS, 0));
      directed_rows.push_back(row(OP_COUNT,     0, 0, 1, ST_OK, 0));
      directed_rows.push_back(row(OP_INS_FRONT, 32'h7fffffff, 0, 1, ST_OK, 1));
      directed_rows.push_back(row(OP_INS_BACK,  32'h80000000, 0, 1, ST_OK, 2));
      directed_rows.push_back(row(OP_INS_POS,   5, 2, 1, ST_BADPOS, 2));
      directed_rows.push_back(row(OP_INS_BACK,  0, 0, 1, ST_OK, 3));
      directed_rows.push_back(row(OP_INS_POS,   32'hffffffff, 2, 0, ST_OK, 0));
      directed_rows.push_back(row(OP_INS_POS,   32'h5a5a5a5a, 3, 0, ST_OK, 0));
      directed_rows.push_back(row(OP_READ_FWD,  0, 0, 0, ST_OK, 0));
      directed_rows.push_back(row(OP_READ_REV,  0, 0, 0, ST_OK, 0));
      directed_rows.push_back(row(OP_DEL_POS,   0, 1, 1, ST_BADPOS, 5));
      directed_rows.push_back(row(OP_DEL_POS,   0, 5, 1, ST_BADPOS, 5));
      directed_rows.push_back(row(OP_DEL_POS,   0, 32, 1, ST_BADPOS, 5));
      directed_rows.push_back(row(OP_DEL_POS,   0, 3, 1, ST_OK, 4));
      directed_rows.push_back(row(OP_INS_POS,   9, 0, 1, ST_BADPOS, 4));
      directed_rows.push_back(row(OP_DEL_FRONT, 0, 31, 1, ST_OK, 3));
      directed_rows.push_back(row(OP_DEL_BACK,  0, 16, 1, ST_OK, 2));
      directed_rows.push_back(row(4'd9,         32'h12345678, 0, 1, ST_OK, 2));
      directed_rows.push_back(row(4'd15,        32'hffffffff, 63, 1, ST_OK, 2));
      directed_rows.push_back(row(OP_COUNT,     0, 0, 1, ST_OK, 2));
      directed_rows.push_back(row(OP_READ_FWD,  0, 0, 0, ST_OK, 0));

      for (k = 0; k < DEPTH; k++) list_cells[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         d = directed_rows[i];
         tr.status = d.status;
         tr.value  = '0;
         tr.count  = d.count;
         tr.last   = 1'b1;
         send_command(d.opcode, d.value, d.position, d.typed, tr);
      end
      wait_drained();

      // Fill the list, push on a full list, then read it whole while the receiver holds off.
      guard = 0;
      while (list_len < DEPTH && guard < 200) begin
         send_random(OP_W'($urandom_range(2)));
         guard++;
      end
      repeat (4) send_random(OP_W'($urandom_range(2)));
      hold_token++;
      send_random(OP_READ_FWD);
      send_random(OP_READ_REV);
      send_random(OP_COUNT);
      wait_drained();

      for (k = 0; k < 300; k++) begin
         no_idle = (k >= 100 && k < 160);
         ins_w = ((k / 50) % 2) ? 25 : 55;
         r = $urandom_range(99);
         if (r < ins_w) op = OP_W'($urandom_range(2));
         else if (r < 72) op = OP_W'($urandom_range(5, 3));
         else if (r < 86) op = $urandom_range(1) ? OP_READ_FWD : OP_READ_REV;
         else if (r < 95) op = OP_COUNT;
         else op = OP_W'($urandom_range(15, 9));
         send_random(op);
      end
      no_idle = 1'b0;
      wait_drained();

      // The sender keeps offering while the receiver holds off, so the input side backs up.
      hold_token++;
      no_idle = 1'b1;
      for (k = 0; k < 20; k++) begin
         send_random($urandom_range(3) == 0 ? OP_COUNT : OP_W'($urandom_range(2)));
      end
      no_idle = 1'b0;
      wait_drained();

      guard = 0;
      while (list_len > 0 && guard < 200) begin
         send_random(OP_W'($urandom_range(5, 3)));
         guard++;
      end
      send_random(OP_DEL_FRONT);
      send_random(OP_DEL_POS);
      send_random(OP_READ_REV);

      wait_drained();
      repeat (DRAIN_LEN) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
